// ===== design/four_channel_crossfade_sequencer_defines.svh =====
// Assertion macros shared by the cross-fade sequencer modules.
// Each module that asserts includes this file; it needs clk and rst in scope.
`ifndef FOUR_CHANNEL_CROSSFADE_SEQUENCER_DEFINES_SVH
`define FOUR_CHANNEL_CROSSFADE_SEQUENCER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CFS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cross-fade sequencer check failed");

// Consequent must hold in the cycle after the antecedent.
`define CFS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cross-fade sequencer check failed");

`endif

// ===== design/cfs_pkg.sv =====
// Shared constants and types for the four-channel cross-fade sequencer.
// No dependencies.
package cfs_pkg;

  localparam int LEVELS_DEF = 64;
  localparam int PERIOD_W   = 16;
  localparam int HOLD_W     = 6;
  localparam int PHASE_W    = 3;
  localparam int CHANNELS   = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [PERIOD_W-1:0] STEP_PERIOD_RST = 16'd150;
  localparam logic [HOLD_W-1:0]   HOLD_LEVEL_RST  = 6'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_PERIOD = 2'd0,
    REG_HOLD_LEVEL  = 2'd1
  } cfg_reg_t;

endpackage

// ===== design/cfs_tick_timer.sv =====
// Base tick counter: raises step when step_period ticks have been counted.
// Depends on cfs_pkg and four_channel_crossfade_sequencer_defines.svh.
`include "four_channel_crossfade_sequencer_defines.svh"

module cfs_tick_timer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         fire,
  input  logic [cfs_pkg::PERIOD_W-1:0] step_period,
  output logic                         step
);

  logic [cfs_pkg::PERIOD_W-1:0] count;
  logic [cfs_pkg::PERIOD_W-1:0] count_next;
  logic [cfs_pkg::PERIOD_W:0]   count_inc;

  // one extra bit so the compare sees the true incremented count
  assign count_inc = {1'b0, count} + 1'b1;
  assign step      = fire && (count_inc >= {1'b0, step_period});

  always_comb begin
    count_next = count;
    if (step) begin
      count_next = '0;
    end else if (fire) begin
      count_next = count_inc[cfs_pkg::PERIOD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  `CFS_ASSERT_NEXT(a_step_clears_count, step, count == '0)
  `CFS_ASSERT_NEXT(a_count_holds_idle, !fire, $stable(count))

endmodule

// ===== design/cfs_fade_core.sv =====
// Phase register and the four channel levels; one fade step per step strobe.
// Depends on cfs_pkg and four_channel_crossfade_sequencer_defines.svh.
`include "four_channel_crossfade_sequencer_defines.svh"

module cfs_fade_core #(
  parameter int LEVELS = cfs_pkg::LEVELS_DEF,
  parameter int LVL_W  = $clog2(LEVELS)
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      step,
  input  logic [cfs_pkg::HOLD_W-1:0]                hold_level,
  output logic [cfs_pkg::CHANNELS-1:0][LVL_W-1:0]   level_next,
  output logic [cfs_pkg::PHASE_W-1:0]               phase_next
);

  localparam int NCH   = cfs_pkg::CHANNELS;
  localparam int HW    = cfs_pkg::HOLD_W;
  localparam int CMP_W = (LVL_W > HW) ? LVL_W : HW;
  localparam logic [LVL_W-1:0] TOP_LVL = LVL_W'(LEVELS - 1);

  logic [NCH-1:0][LVL_W-1:0]       level;
  logic [cfs_pkg::PHASE_W-1:0]     phase;
  logic [cfs_pkg::PHASE_W-1:0]     phase_inc;
  logic [NCH-1:0]                  cur_mask;
  logic [NCH-1:0]                  at_top;
  logic [NCH-1:0]                  above_hold;
  logic                            cur_top;
  logic                            cur_above;

  assign phase_inc = phase + 1'b1;

  for (genvar c = 0; c < NCH; c++) begin : g_lane
    localparam logic [1:0] CH  = 2'(c);
    localparam logic [1:0] NXT = 2'((c + 1) % NCH);
    logic is_cur;
    logic is_prev;

    // channel k ramps in phase 2k; the channel before it fades out
    assign is_cur        = (phase[2:1] == CH);
    assign is_prev       = (phase[2:1] == NXT);
    assign cur_mask[c]   = is_cur;
    assign at_top[c]     = (level[c] == TOP_LVL);
    assign above_hold[c] = (CMP_W'(level[c]) > CMP_W'(hold_level));

    always_comb begin
      level_next[c] = level[c];
      if (step) begin
        if (!phase[0]) begin
          if (is_prev && (level[c] != '0)) begin
            level_next[c] = level[c] - 1'b1;
          end else if (is_cur && !at_top[c]) begin
            level_next[c] = level[c] + 1'b1;
          end
        end else if (is_cur && above_hold[c]) begin
          level_next[c] = level[c] - 1'b1;
        end
      end
    end
  end

  assign cur_top   = |(at_top & cur_mask);
  assign cur_above = |(above_hold & cur_mask);

  always_comb begin
    phase_next = phase;
    if (step) begin
      // advance only once the current channel has reached its target
      if (!phase[0]) begin
        if (cur_top) begin
          phase_next = phase_inc;
        end
      end else if (!cur_above) begin
        phase_next = phase_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
      phase <= '0;
    end else begin
      level <= level_next;
      phase <= phase_next;
    end
  end

  `CFS_ASSERT_NEXT(a_phase_holds_idle, !step, $stable(phase) && $stable(level))
  `CFS_ASSERT_NEXT(a_phase_moves_by_one, step, (phase == $past(phase)) || (phase == $past(phase_inc)))
  `CFS_ASSERT_SAME(a_one_current_lane, 1'b1, $onehot(cur_mask))

endmodule

// ===== design/four_channel_crossfade_sequencer.sv =====
// Top level of the four-channel cross-fade sequencer: input register,
// configuration registers, result register. Depends on cfs_pkg,
// cfs_tick_timer, cfs_fade_core and four_channel_crossfade_sequencer_defines.svh.
//
//   channel | handshake                  | payload
//   --------+----------------------------+----------------------------------------
//   tick    | tick_valid / tick_stall    | elapsed
//   result  | result_valid / result_stall| blue/green/yellow/red_level, fade_phase,
//           |                            | stepped
//   cfg     | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One tick per clock while the result is not stalled; a tick's result passes through
// the input register, then the result register. The counter compare and the lane
// updates sit between those two registers. rst is synchronous and clears the
// counter, phase and levels and loads step_period 150, hold_level 10.
// A stalled result holds the input register, which then stalls the tick channel.
// cfg_ready is always high.
`include "four_channel_crossfade_sequencer_defines.svh"

module four_channel_crossfade_sequencer #(
  parameter int LEVELS = cfs_pkg::LEVELS_DEF,
  parameter int LVL_W  = $clog2(LEVELS)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           tick_valid,
  output logic                           tick_stall,
  input  logic                           elapsed,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic [LVL_W-1:0]               blue_level,
  output logic [LVL_W-1:0]               green_level,
  output logic [LVL_W-1:0]               yellow_level,
  output logic [LVL_W-1:0]               red_level,
  output logic [cfs_pkg::PHASE_W-1:0]    fade_phase,
  output logic                           stepped,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cfs_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [cfs_pkg::PERIOD_W-1:0]              step_period;
  logic [cfs_pkg::HOLD_W-1:0]                hold_level;
  logic                                      s1_valid;
  logic                                      s1_elapsed;
  logic                                      res_free;
  logic                                      s1_move;
  logic                                      tick_take;
  logic                                      fire;
  logic                                      step;
  logic [cfs_pkg::CHANNELS-1:0][LVL_W-1:0]   level_next;
  logic [cfs_pkg::PHASE_W-1:0]               phase_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_period <= cfs_pkg::STEP_PERIOD_RST;
      hold_level  <= cfs_pkg::HOLD_LEVEL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cfs_pkg::REG_STEP_PERIOD: step_period <= cfg_data[cfs_pkg::PERIOD_W-1:0];
        cfs_pkg::REG_HOLD_LEVEL:  hold_level  <= cfg_data[cfs_pkg::HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // input register moves on whenever the result register is free
  assign res_free   = !result_valid || !result_stall;
  assign s1_move    = s1_valid && res_free;
  assign tick_stall = s1_valid && !res_free;
  assign tick_take  = tick_valid && !tick_stall;
  assign fire       = s1_move && s1_elapsed;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick_take) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_take) begin
      s1_elapsed <= elapsed;
    end
  end

  cfs_tick_timer u_tick (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .step_period (step_period),
    .step        (step)
  );

  cfs_fade_core #(
    .LEVELS (LEVELS),
    .LVL_W  (LVL_W)
  ) u_fade (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .hold_level (hold_level),
    .level_next (level_next),
    .phase_next (phase_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_move) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      blue_level   <= level_next[0];
      green_level  <= level_next[1];
      yellow_level <= level_next[2];
      red_level    <= level_next[3];
      fade_phase   <= phase_next;
      stepped      <= step;
    end
  end

  `CFS_ASSERT_NEXT(a_move_loads_result, s1_move, result_valid)
  `CFS_ASSERT_SAME(a_step_needs_transfer, step, s1_move && s1_elapsed)

endmodule
